[hdl/ipv4f_pkg.sv]
// ipv4f_pkg: shared types and constants for the ipv4 receive header filter
// used by the front parser, the summary queue, the verdict stage and the top level
// no dependencies

package ipv4f_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_TDATA_W = 136;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_ADDR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NET_MASK   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTRA_ADDR = 2'd2;

   localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;
   localparam logic [15:0] MIN_PKT_BYTES  = 16'd20;
   localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [15:0] FRAG_MASK      = 16'h3FFF;
   localparam logic [7:0]  LOOPBACK_NET   = 8'd127;
   localparam logic [31:0] BCAST_ADDR     = 32'hFFFF_FFFF;
   localparam logic [15:0] SUM_GOOD       = 16'hFFFF;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   typedef enum logic [1:0] {
      CLASS_ICMP  = 2'd0,
      CLASS_UDP   = 2'd1,
      CLASS_TCP   = 2'd2,
      CLASS_OTHER = 2'd3
   } proto_class_type;

   typedef enum logic [2:0] {
      REASON_NONE     = 3'd0,
      REASON_SHORT    = 3'd1,
      REASON_VERSION  = 3'd2,
      REASON_LENGTH   = 3'd3,
      REASON_CHECKSUM = 3'd4,
      REASON_FRAGMENT = 3'd5,
      REASON_NOT_OURS = 3'd6,
      REASON_PROTOCOL = 3'd7
   } drop_reason_type;

   // everything the parser collected for one packet
   typedef struct packed {
      logic [15:0] byte_count;
      logic [7:0]  ver_ihl;
      logic [15:0] total_len;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [16:0] sum;
   } summary_type;

endpackage

[hdl/ipv4f_front.sv]
// ipv4f_front: byte-serial header parser, captures fields and folds the header checksum
// depends on ipv4f_pkg

module ipv4f_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   queue_full,
   output logic                   push,
   output ipv4f_pkg::summary_type push_data
);

   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  ver_ihl_ff, ver_ihl_in;
   logic [15:0] total_len_ff, total_len_in;
   logic [15:0] frag_ff, frag_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [16:0] sum_ff, sum_in;
   logic [7:0]  high_half_ff, high_half_in;

   logic        accept;
   logic [5:0]  hdr_len;
   logic [16:0] word_sum;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && req_tlast;

   always_comb begin
      byte_count_in = byte_count_ff;
      ver_ihl_in    = ver_ihl_ff;
      total_len_in  = total_len_ff;
      frag_in       = frag_ff;
      proto_in      = proto_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      sum_in        = sum_ff;
      high_half_in  = high_half_ff;
      hdr_len       = {ver_ihl_ff[3:0], 2'b00};
      word_sum      = sum_ff + {1'b0, high_half_ff, req_tdata};

      if (byte_count_ff != ipv4f_pkg::BYTE_COUNT_MAX) begin
         byte_count_in = byte_count_ff + 16'd1;
         // header length is known from the very first byte on
         if (byte_count_ff == 16'd0) begin
            hdr_len = {req_tdata[3:0], 2'b00};
         end

         case (byte_count_ff)
            16'd0: ver_ihl_in = req_tdata;
            16'd2: total_len_in = {req_tdata, total_len_ff[7:0]};
            16'd3: total_len_in = {total_len_ff[15:8], req_tdata};
            16'd6: frag_in = {req_tdata, frag_ff[7:0]};
            16'd7: frag_in = {frag_ff[15:8], req_tdata};
            16'd9: proto_in = req_tdata;
            default: ;
         endcase

         if (byte_count_ff >= 16'd12 && byte_count_ff <= 16'd15) begin
            src_in = {src_ff[23:0], req_tdata};
         end else if (byte_count_ff >= 16'd16 && byte_count_ff <= 16'd19) begin
            dst_in = {dst_ff[23:0], req_tdata};
         end

         if (byte_count_ff < {10'd0, hdr_len}) begin
            if (!byte_count_ff[0]) begin
               high_half_in = req_tdata;
            end else begin
               // end-around carry
               sum_in = {1'b0, word_sum[15:0]} + {16'd0, word_sum[16]};
            end
         end
      end
   end

   always_comb begin
      push_data.byte_count = byte_count_in;
      push_data.ver_ihl    = ver_ihl_in;
      push_data.total_len  = total_len_in;
      push_data.frag       = frag_in;
      push_data.proto      = proto_in;
      push_data.src        = src_in;
      push_data.dst        = dst_in;
      push_data.sum        = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         byte_count_ff <= '0;
         ver_ihl_ff    <= '0;
         total_len_ff  <= '0;
         frag_ff       <= '0;
         proto_ff      <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
         sum_ff        <= '0;
         high_half_ff  <= '0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         ver_ihl_ff    <= ver_ihl_in;
         total_len_ff  <= total_len_in;
         frag_ff       <= frag_in;
         proto_ff      <= proto_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         sum_ff        <= sum_in;
         high_half_ff  <= high_half_in;
      end
   end

endmodule

[hdl/ipv4f_queue.sv]
// ipv4f_queue: short fifo of packet summaries between parser and verdict stage
// depends on ipv4f_pkg

module ipv4f_queue #(
   parameter int Depth = ipv4f_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ipv4f_pkg::summary_type push_data,
   output logic                   full,
   output logic                   head_valid,
   output ipv4f_pkg::summary_type head_data,
   input  logic                   pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   ipv4f_pkg::summary_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/ipv4f_back.sv]
// ipv4f_back: verdict stage, runs the ordered drop checks, keeps the drop counter
// and holds the result register; also owns the interface address registers
// depends on ipv4f_pkg

module ipv4f_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ipv4f_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ipv4f_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 head_valid,
   input  ipv4f_pkg::summary_type               head_data,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ipv4f_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic [31:0] local_addr_ff, net_mask_ff, extra_addr_ff;
   logic [31:0] drop_count_ff, drop_count_in;
   logic        rsp_valid_ff;
   logic [ipv4f_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   ipv4f_pkg::drop_reason_type reason;
   ipv4f_pkg::proto_class_type cls;
   logic [5:0]  ihl_bytes;
   logic        is_bcast, is_local, dest_ours;

   assign pop        = head_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign ihl_bytes  = {head_data.ver_ihl[3:0], 2'b00};

   always_comb begin
      is_bcast = (head_data.dst == ipv4f_pkg::BCAST_ADDR) ||
                 (local_addr_ff != '0 && net_mask_ff != '0 &&
                  head_data.dst == ((local_addr_ff & net_mask_ff) | ~net_mask_ff));
      is_local = (head_data.dst[31:24] == ipv4f_pkg::LOOPBACK_NET) ||
                 (local_addr_ff != '0 && head_data.dst == local_addr_ff) ||
                 (extra_addr_ff != '0 && head_data.dst == extra_addr_ff);
      // unconfigured interface takes everything
      dest_ours = is_bcast || is_local || (local_addr_ff == '0);
   end

   always_comb begin
      if (head_data.byte_count < ipv4f_pkg::MIN_PKT_BYTES) begin
         reason = ipv4f_pkg::REASON_SHORT;
      end else if (head_data.ver_ihl[7:4] != ipv4f_pkg::IP_VERSION_4) begin
         reason = ipv4f_pkg::REASON_VERSION;
      end else if (ihl_bytes < ipv4f_pkg::MIN_HDR_BYTES ||
                   head_data.total_len < {10'd0, ihl_bytes} ||
                   head_data.total_len > head_data.byte_count) begin
         reason = ipv4f_pkg::REASON_LENGTH;
      end else if (head_data.sum[15:0] != ipv4f_pkg::SUM_GOOD) begin
         reason = ipv4f_pkg::REASON_CHECKSUM;
      end else if ((head_data.frag & ipv4f_pkg::FRAG_MASK) != '0) begin
         reason = ipv4f_pkg::REASON_FRAGMENT;
      end else if (!dest_ours) begin
         reason = ipv4f_pkg::REASON_NOT_OURS;
      end else if (head_data.proto != ipv4f_pkg::PROTO_ICMP &&
                   head_data.proto != ipv4f_pkg::PROTO_UDP &&
                   head_data.proto != ipv4f_pkg::PROTO_TCP) begin
         reason = ipv4f_pkg::REASON_PROTOCOL;
      end else begin
         reason = ipv4f_pkg::REASON_NONE;
      end
   end

   always_comb begin
      unique case (head_data.proto)
         ipv4f_pkg::PROTO_ICMP: cls = ipv4f_pkg::CLASS_ICMP;
         ipv4f_pkg::PROTO_UDP:  cls = ipv4f_pkg::CLASS_UDP;
         ipv4f_pkg::PROTO_TCP:  cls = ipv4f_pkg::CLASS_TCP;
         default:               cls = ipv4f_pkg::CLASS_OTHER;
      endcase
   end

   always_comb begin
      drop_count_in = drop_count_ff;
      if (reason != ipv4f_pkg::REASON_NONE) begin
         drop_count_in = drop_count_ff + 32'd1;
      end
      rsp_tdata_in = {4'd0, drop_count_in, head_data.dst, head_data.src,
                      head_data.total_len, ihl_bytes, head_data.proto, cls, reason,
                      (reason == ipv4f_pkg::REASON_NONE)};
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
         net_mask_ff   <= '0;
         extra_addr_ff <= '0;
         drop_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ipv4f_pkg::CSR_LOCAL_ADDR: local_addr_ff <= csr_wdata;
               ipv4f_pkg::CSR_NET_MASK:   net_mask_ff   <= csr_wdata;
               ipv4f_pkg::CSR_EXTRA_ADDR: extra_addr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (pop) begin
            rsp_valid_ff  <= 1'b1;
            drop_count_ff <= drop_count_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

[hdl/ipv4_rx_header_filter_top.sv]
// a summary enters the queue on the last byte's transaction; the verdict stage then
//   pops it into the result register; throughput: one byte per cycle while req_tready
//   is high; one verdict per cycle while rsp_tready is high, draining the summary queue
// req_tready drops only while the summary queue (QueueDepth entries) is full
// reset: synchronous, active high; clears packet state, queue, drop counter and registers
// ipv4_rx_header_filter_top: depends on ipv4f_pkg, ipv4f_front, ipv4f_queue, ipv4f_back

module ipv4_rx_header_filter_top #(
   parameter int QueueDepth = ipv4f_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic                               req_tlast,  // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // accepted, drop_reason[3], proto_class[2], protocol_number[8], header_bytes[6],
   // total_bytes[16], source_addr[32], dest_addr[32], dropped_count[32], zero fill
   output logic [ipv4f_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                               csr_we,
   input  logic [ipv4f_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ipv4f_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                   push, queue_full, head_valid, pop;
   ipv4f_pkg::summary_type push_data, head_data;

   ipv4f_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   ipv4f_queue #(.Depth(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   ipv4f_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hdl/ipv4f_checker.sv]
// ipv4f_checker: port-level assertions for ipv4_rx_header_filter_top, bound to it below
// depends on ipv4f_pkg

module ipv4f_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ipv4f_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic        have_prev_ff;
   logic [31:0] prev_count_ff;
   logic        rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         prev_count_ff <= '0;
      end else if (rsp_xfer) begin
         have_prev_ff  <= 1'b1;
         prev_count_ff <= rsp_tdata[131:100];
      end
   end

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // accept flag and drop reason agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == 3'd0)))
      else $error("accepted flag disagrees with drop reason");

   // drop counter advances by one on each dropped verdict only
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && have_prev_ff |->
         rsp_tdata[131:100] == prev_count_ff + {31'd0, (rsp_tdata[3:1] != 3'd0)})
      else $error("drop counter out of step");

   // an accepted packet has sane lengths
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[19:14] >= 6'd20 && rsp_tdata[35:20] >= {10'd0, rsp_tdata[19:14]})
      else $error("accepted packet with bad header length");

endmodule

bind ipv4_rx_header_filter_top ipv4f_checker u_ipv4f_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
